[rtl/fwsm_pkg.sv]
// Shared types and constants for the FIFO with search and maximum.
// Used by fwsm_cmp and fifo_with_search_and_max; no dependencies.
package fwsm_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STS_W     = 2;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned IN_W      = 40;  // cmd + value, padded to whole bytes
  localparam int unsigned OUT_W     = 72;  // status + result + found + front + occupancy

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_MAX    = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_UNDER = 2'd1,
    STS_OVER  = 2'd2
  } status_e;

  // Control word from the sequencer to the shared compare unit
  typedef struct packed {
    logic clear;   // start of a new item: drop the accumulated result
    logic vld;     // a stored word is present on the data input
    logic is_max;  // 1: track maximum, 0: match against key
  } cmp_ctrl_t;

endpackage

[rtl/fwsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fwsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fwsm_cmp.sv]
// Shared compare unit: key match and signed running maximum over scanned words.
// Depends on fwsm_pkg.
module fwsm_cmp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fwsm_pkg::cmp_ctrl_t               ctrl_i,
  input  logic signed [fwsm_pkg::DATA_W-1:0] key_i,
  input  logic signed [fwsm_pkg::DATA_W-1:0] data_i,
  output logic signed [fwsm_pkg::DATA_W-1:0] max_o,
  output logic                              found_o
);

  logic signed [fwsm_pkg::DATA_W-1:0] max_q, max_d;
  logic                               found_q, found_d;
  logic                               first_q, first_d;

  always_comb begin
    max_d   = max_q;
    found_d = found_q;
    first_d = first_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
      first_d = 1'b1;
    end else if (ctrl_i.vld) begin
      if (ctrl_i.is_max) begin
        // keep the earliest word on a tie
        if (first_q || (data_i > max_q)) begin
          max_d = data_i;
        end
        first_d = 1'b0;
      end else if (data_i == key_i) begin
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      first_q <= 1'b1;
    end else begin
      found_q <= found_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
  end

  assign max_o   = max_q;
  assign found_o = found_q;

endmodule

[rtl/fifo_with_search_and_max.sv]
// Top level of the FIFO with search and maximum: sequencer, ring pointers, output register.
// Depends on fwsm_pkg, fwsm_ram and fwsm_cmp.
//
// Usage:
//   Input words arrive on s_axis_*: a command (enqueue, dequeue, search, maximum)
//   and a 32-bit signed value. Each accepted word yields exactly one output word on
//   m_axis_*: status, dequeued item or maximum, found flag, front item and occupancy.
//   s_axis_tready_o is high only while the sequencer is idle; one word is worked on
//   at a time.
//   Each accepted word passes through the execute state; a dequeue then reads and
//   removes the front slot, and search and maximum scan the stored items (at most
//   DEPTH; maximum skips the scan on an empty queue) before the front read and output.
//   The scan issues one ring read per cycle through the single RAM read port and
//   feeds the shared compare unit.
//   Enqueue on a full queue is dropped with overflow status; dequeue or maximum on
//   an empty queue returns underflow with a zero result.
//   Reset clears the pointers, the count and the output valid; the ring RAM needs
//   no clearing since only occupied slots are ever read.
//   A finished word waits in the output register while the next input word is
//   accepted; the sequencer holds in its final state until that register is free.
module fifo_with_search_and_max #(
  parameter int unsigned DEPTH = fwsm_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [1:0] cmd, [33:2] value, [39:34] zero
  input  logic [fwsm_pkg::IN_W-1:0]    s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [1:0] status, [33:2] result_value, [34] found, [66:35] front_value,
  // [71:67] occupancy
  output logic [fwsm_pkg::OUT_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_EXEC       = 7'b0000010,
    S_DEQ_WAIT   = 7'b0000100,
    S_SCAN       = 7'b0001000,
    S_FRONT      = 7'b0010000,
    S_FRONT_WAIT = 7'b0100000,
    S_DONE       = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  fwsm_pkg::cmd_e                       cmd_q, cmd_d;
  logic signed [fwsm_pkg::DATA_W-1:0]   val_q, val_d;
  logic [AW-1:0]                        head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]                        count_q, count_d;
  logic [AW-1:0]                        scan_idx_q, scan_idx_d;
  logic [CW-1:0]                        issued_q, issued_d;
  logic                                 pend_q, pend_d;
  fwsm_pkg::status_e                    status_q, status_d;
  logic signed [fwsm_pkg::DATA_W-1:0]   res_q, res_d;
  logic signed [fwsm_pkg::DATA_W-1:0]   front_q, front_d;
  logic                                 m_valid_q, m_valid_d;
  logic [fwsm_pkg::OUT_W-1:0]           m_data_q, m_data_d;

  logic                                 full, empty;
  logic                                 ram_we;
  logic [AW-1:0]                        ram_raddr;
  logic signed [fwsm_pkg::DATA_W-1:0]   ram_rdata;
  fwsm_pkg::cmp_ctrl_t                  cmp_ctrl;
  logic signed [fwsm_pkg::DATA_W-1:0]   cmp_max;
  logic                                 cmp_found;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : AW'(idx + 1'b1);
  endfunction

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  fwsm_ram #(
    .WIDTH(fwsm_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(val_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  fwsm_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .key_i  (val_q),
    .data_i (ram_rdata),
    .max_o  (cmp_max),
    .found_o(cmp_found)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Read port: the scan walks its own index, everything else reads the front slot
  always_comb begin
    case (state_q)
      S_SCAN:  ram_raddr = scan_idx_q;
      default: ram_raddr = head_q;
    endcase
  end

  assign ram_we = (state_q == S_EXEC) && (cmd_q == fwsm_pkg::CMD_ENQ) && !full;

  assign cmp_ctrl.clear  = (state_q == S_EXEC);
  assign cmp_ctrl.vld    = (state_q == S_SCAN) && pend_q;
  assign cmp_ctrl.is_max = (cmd_q == fwsm_pkg::CMD_MAX);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    val_d      = val_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    issued_d   = issued_q;
    pend_d     = pend_q;
    status_d   = status_q;
    res_d      = res_q;
    front_d    = front_q;
    m_data_d   = m_data_q;
    // drop the output word once the receiver takes it
    m_valid_d  = m_valid_q && !m_axis_tready_i;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = fwsm_pkg::cmd_e'(s_axis_tdata_i[1:0]);
          val_d   = s_axis_tdata_i[33:2];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d   = fwsm_pkg::STS_OK;
        res_d      = '0;
        scan_idx_d = head_q;
        issued_d   = '0;
        pend_d     = 1'b0;
        case (cmd_q)
          fwsm_pkg::CMD_ENQ: begin
            if (full) begin
              status_d = fwsm_pkg::STS_OVER;
            end else begin
              tail_d  = next_slot(tail_q);
              count_d = CW'(count_q + 1'b1);
            end
            state_d = S_FRONT;
          end
          fwsm_pkg::CMD_DEQ: begin
            if (empty) begin
              status_d = fwsm_pkg::STS_UNDER;
              state_d  = S_FRONT;
            end else begin
              state_d = S_DEQ_WAIT;
            end
          end
          fwsm_pkg::CMD_SEARCH: begin
            state_d = S_SCAN;
          end
          default: begin
            if (empty) begin
              status_d = fwsm_pkg::STS_UNDER;
              state_d  = S_FRONT;
            end else begin
              state_d = S_SCAN;
            end
          end
        endcase
      end
      S_DEQ_WAIT: begin
        res_d   = ram_rdata;
        head_d  = next_slot(head_q);
        count_d = CW'(count_q - 1'b1);
        state_d = S_FRONT;
      end
      S_SCAN: begin
        // issue one read per cycle; each compare lands in the following cycle
        if (issued_q != count_q) begin
          issued_d   = CW'(issued_q + 1'b1);
          scan_idx_d = next_slot(scan_idx_q);
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (cmd_q == fwsm_pkg::CMD_MAX) begin
              res_d = cmp_max;
            end
            state_d = S_FRONT;
          end
        end
      end
      S_FRONT: begin
        state_d = S_FRONT_WAIT;
      end
      S_FRONT_WAIT: begin
        front_d = empty ? '0 : ram_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_data_d  = {fwsm_pkg::OCC_W'(count_q), front_q,
                       (cmd_q == fwsm_pkg::CMD_SEARCH) && cmp_found, res_q, status_q};
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      issued_q  <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      issued_q  <= issued_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    scan_idx_q <= scan_idx_d;
    status_q   <= status_d;
    res_q      <= res_d;
    front_q    <= front_d;
    m_data_q   <= m_data_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("item count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> (head_q == tail_q))
    else $error("head and tail disagree with count");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == fwsm_pkg::CMD_ENQ && !full)
      |=> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("enqueue did not advance count");

  a_scan_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (issued_q <= count_q))
    else $error("scan issued beyond stored items");
`endif

endmodule
